[rtl/krt_pkg.sv]
`timescale 1ns / 1ps
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_BITS  = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NUM_CRD     = 6;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_MODIFY = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef logic signed [COORD_BITS-1:0] crd_t;

  typedef struct packed {
    logic [15:0]              key;
    logic [1:0]               kind;
    crd_t [NUM_CRD-1:0]       coord;
  } rec_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [1:0]         kind;
    logic [15:0]        key;
    logic signed [15:0] coord_a;
    logic signed [15:0] coord_b;
    logic signed [15:0] coord_c;
    logic signed [15:0] coord_d;
    logic signed [15:0] coord_e;
    logic signed [15:0] coord_f;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        result_key;
    logic [1:0]         found_kind;
    logic signed [15:0] out_a;
    logic signed [15:0] out_b;
    logic signed [15:0] out_c;
    logic signed [15:0] out_d;
    logic signed [15:0] out_e;
    logic signed [15:0] out_f;
    logic [6:0]         entries_used;
  } out_word_t;

  typedef enum logic [2:0] {
    RES_DONE,
    RES_FULL,
    RES_MISS,
    RES_ADD,
    RES_HIT,
    RES_LOOK
  } res_sel_t;

  typedef struct packed {
    logic     latch;
    logic     scan_start;
    logic     scan_step;
    logic     add;
    logic     mod_write;
    logic     shift_write;
    logic     dec_used;
    logic     clear;
    logic     res_load;
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       hit;
    logic       last;
    logic       out_free;
  } sts_t;

  function automatic crd_t to_crd(input logic signed [15:0] v);
    return COORD_BITS'(v);
  endfunction

  function automatic logic signed [15:0] from_crd(input crd_t c);
    return 16'(c);
  endfunction

endpackage

[rtl/krt_ram.sv]
`timescale 1ns / 1ps
module krt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/krt_ctrl.sv]
`timescale 1ns / 1ps
module krt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  krt_pkg::sts_t sts,
  output krt_pkg::cmd_t cmd
);
  import krt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_ADD: begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.add     = 1'b1;
              cmd.res_sel = RES_ADD;
            end
            state_nxt = S_FIN;
          end
          OP_DELETE, OP_MODIFY, OP_LOOKUP: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_MISS;
              state_nxt    = S_FIN;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_DONE;
            state_nxt    = S_FIN;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_DONE;
            state_nxt    = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = (sts.op == OP_LOOKUP) ? RES_LOOK : RES_HIT;
          state_nxt    = S_FIN;
          case (sts.op)
            OP_MODIFY: begin
              cmd.mod_write = 1'b1;
            end
            OP_DELETE: begin
              // hit on the tail entry needs no compaction
              if (sts.last) begin
                cmd.dec_used = 1'b1;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end else if (sts.last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MISS;
          state_nxt    = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd.scan_step   = 1'b1;
        cmd.shift_write = 1'b1;
        if (sts.last) begin
          cmd.dec_used = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/krt_dp.sv]
`timescale 1ns / 1ps
module krt_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  krt_pkg::in_word_t  in_data,
  input  krt_pkg::cmd_t      cmd,
  output krt_pkg::sts_t      sts,
  input  logic               out_ready,
  output logic               out_valid,
  output krt_pkg::out_word_t out_data
);
  import krt_pkg::*;

  in_word_t           in_r;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [15:0]        key_ctr_r, key_ctr_nxt;
  logic [CNT_W-1:0]   idx_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;
  out_word_t          res_r, res_nxt;
  out_word_t          out_r, out_nxt;
  logic               out_vld_r;

  rec_t               rdata;
  rec_t               wdata;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  crd_t [NUM_CRD-1:0] in_crd;
  logic               full;

  assign in_crd[0] = to_crd(in_r.coord_a);
  assign in_crd[1] = to_crd(in_r.coord_b);
  assign in_crd[2] = to_crd(in_r.coord_c);
  assign in_crd[3] = to_crd(in_r.coord_d);
  assign in_crd[4] = to_crd(in_r.coord_e);
  assign in_crd[5] = to_crd(in_r.coord_f);

  assign full = (used_r == CNT_W'(TABLE_DEPTH));

  assign sts.op       = in_r.operation;
  assign sts.full     = full;
  assign sts.empty    = (used_r == '0);
  assign sts.hit      = cmp_vld_r && (rdata.key == in_r.key);
  assign sts.last     = cmp_vld_r && (CNT_W'(cmp_idx_r) == used_r - CNT_W'(1));
  assign sts.out_free = !out_vld_r || out_ready;

  // single write port: append, rewrite in place, or move one entry down
  always_comb begin
    we    = 1'b0;
    waddr = used_r[IDX_W-1:0];
    wdata = '{key: key_ctr_r, kind: in_r.kind, coord: in_crd};
    if (cmd.add) begin
      we = 1'b1;
    end else if (cmd.mod_write) begin
      we    = 1'b1;
      waddr = cmp_idx_r;
      wdata = '{key: in_r.key, kind: rdata.kind, coord: in_crd};
    end else if (cmd.shift_write) begin
      we    = 1'b1;
      waddr = cmp_idx_r - IDX_W'(1);
      wdata = rdata;
    end
  end

  krt_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH($bits(rec_t))
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    used_nxt    = used_r;
    key_ctr_nxt = key_ctr_r;
    if (cmd.clear) begin
      used_nxt    = '0;
      key_ctr_nxt = 16'd1;
    end else if (cmd.add) begin
      used_nxt    = used_r + CNT_W'(1);
      key_ctr_nxt = (key_ctr_r == 16'hFFFF) ? 16'd1 : key_ctr_r + 16'd1;
    end else if (cmd.dec_used) begin
      used_nxt = used_r - CNT_W'(1);
    end
  end

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      RES_FULL: begin
        res_nxt.status = ST_FULL;
      end
      RES_MISS: begin
        res_nxt.status = ST_MISS;
      end
      RES_ADD: begin
        res_nxt.status     = ST_DONE;
        res_nxt.result_key = key_ctr_r;
      end
      RES_HIT: begin
        res_nxt.status     = ST_DONE;
        res_nxt.result_key = in_r.key;
      end
      RES_LOOK: begin
        res_nxt.status     = ST_DONE;
        res_nxt.result_key = in_r.key;
        res_nxt.found_kind = rdata.kind;
        res_nxt.out_a      = from_crd(rdata.coord[0]);
        res_nxt.out_b      = from_crd(rdata.coord[1]);
        res_nxt.out_c      = from_crd(rdata.coord[2]);
        res_nxt.out_d      = from_crd(rdata.coord[3]);
        res_nxt.out_e      = from_crd(rdata.coord[4]);
        res_nxt.out_f      = from_crd(rdata.coord[5]);
      end
      default: begin
        res_nxt.status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    out_nxt              = res_r;
    out_nxt.entries_used = 7'(used_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      key_ctr_r <= 16'd1;
      idx_r     <= '0;
      cmp_idx_r <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      used_r    <= used_nxt;
      key_ctr_r <= key_ctr_nxt;
      // read address runs one entry ahead of the compare
      if (cmd.scan_start) begin
        idx_r     <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (idx_r < used_r) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        cmp_idx_r <= idx_r[IDX_W-1:0];
        cmp_vld_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    key_ctr_r != 16'd0)
    else $error("key counter reached zero");

  a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add |-> !full)
    else $error("append issued on a full table");

  a_write_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mod_write || cmd.shift_write) |-> (CNT_W'(waddr) < used_r))
    else $error("in-place write outside the used range");

  a_shift_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_write && !$past(cmd.shift_write)) |-> $past(sts.hit))
    else $error("compaction started without a matching entry");

endmodule

[rtl/keyed_record_table.sv]
// Shape record table, up to 64 records in insertion order, one word at a time.
// Add, clear and unused codes finish without a scan; delete, modify and lookup scan
// the records held in insertion order, and a delete compacts the entries behind
// the hit one entry at a time. A new word is taken only after the last result
// has been loaded into the output register.
// Synchronous active-low reset empties the table and sets the next key to 1.
`timescale 1ns / 1ps
module keyed_record_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  krt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output krt_pkg::out_word_t out_data
);
  import krt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  krt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  krt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
